/* hw/rtl/mp2d_pkg.sv */
// shared constants, types and helpers for the 2-d max pooling stream block
// no dependencies
package mp2d_pkg;

  localparam int PIXEL_WIDTH_DEF = 16;
  localparam int LINE_DEPTH_DEF  = 1024;

  localparam int CNT_W      = 12;  // row and column counters, frame sizes
  localparam int OW_W       = 11;  // out_width register
  localparam int STRIDE_W   = 5;   // stride registers
  localparam int PH_W       = 4;   // window phases
  localparam int OCOL_W     = 10;  // output column counter
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [OCOL_W-1:0] OCOL_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_Y  = 3'd4;

  // reset values
  localparam logic [CNT_W-1:0]    IN_HEIGHT_RST = 12'd20;
  localparam logic [CNT_W-1:0]    IN_WIDTH_RST  = 12'd20;
  localparam logic [OW_W-1:0]     OUT_WIDTH_RST = 11'd10;
  localparam logic [STRIDE_W-1:0] STRIDE_RST    = 5'd2;
  localparam logic [STRIDE_W-1:0] STRIDE_MIN    = 5'd1;
  localparam logic [STRIDE_W-1:0] STRIDE_MAX    = 5'd16;

  // line buffer request from the counter stage
  typedef struct packed {
    logic              vld;
    logic [OCOL_W-1:0] idx;
    logic              restart;  // first row of a vertical window
    logic              last;     // last row of a vertical window
  } line_req_t;

  // zero acts as one, anything above 16 as 16
  function automatic logic [STRIDE_W-1:0] eff_stride(input logic [STRIDE_W-1:0] s);
    logic [STRIDE_W-1:0] r;
    if (s == '0) begin
      r = STRIDE_MIN;
    end else if (s > STRIDE_MAX) begin
      r = STRIDE_MAX;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/mp2d_pix_if.sv */
// input word channel: one signed pixel per word
// no dependencies
interface mp2d_pix_if #(
  parameter int W = 16
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

/* hw/rtl/mp2d_pool_if.sv */
// result word channel: one pooled maximum per word
// no dependencies
interface mp2d_pool_if #(
  parameter int W = 16
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] pooled;

  modport source (output valid, output pooled, input ready);
  modport sink   (input valid, input pooled, output ready);
endinterface

/* hw/rtl/mp2d_cfg_if.sv */
// register write channel: index and write data
// depends on mp2d_pkg
interface mp2d_cfg_if
  import mp2d_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/mp2d_ctrl.sv */
// configuration registers, raster counters and horizontal running maximum
// depends on mp2d_pkg, mp2d_pix_if, mp2d_cfg_if
module mp2d_ctrl
  import mp2d_pkg::*;
#(
  parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF,
  parameter int LINE_DEPTH  = LINE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mp2d_pix_if.sink                      in_pix,
  mp2d_cfg_if.sink                      cfg_wr,
  input  logic                          adv,
  output line_req_t                     req,
  output logic signed [PIXEL_WIDTH-1:0] req_val
);

  logic [CNT_W-1:0]    in_height_r, in_width_r;
  logic [OW_W-1:0]     out_width_r;
  logic [STRIDE_W-1:0] stride_x_r, stride_y_r;

  logic [CNT_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [PH_W-1:0]   xph_r, xph_nxt, yph_r, yph_nxt;
  logic [OCOL_W-1:0] ocol_r, ocol_nxt;
  logic signed [PIXEL_WIDTH-1:0] row_max_r, row_max_nxt;

  logic [STRIDE_W-1:0] sx, sy;
  logic fire, xend, yend, in_limit, col_end, row_end;

  assign cfg_wr.ready = 1'b1;
  assign in_pix.ready = adv;
  assign fire = in_pix.valid & adv;

  assign sx = eff_stride(stride_x_r);
  assign sy = eff_stride(stride_y_r);

  assign xend     = ({1'b0, xph_r} + 5'd1) >= sx;
  assign yend     = ({1'b0, yph_r} + 5'd1) >= sy;
  assign in_limit = ({1'b0, ocol_r} < out_width_r) && (32'(ocol_r) < 32'(LINE_DEPTH));
  assign col_end  = ({1'b0, col_r} + 13'd1) >= {1'b0, in_width_r};
  assign row_end  = ({1'b0, row_r} + 13'd1) >= {1'b0, in_height_r};

  always_comb begin
    if (xph_r == '0 || in_pix.pixel > row_max_r) begin
      row_max_nxt = in_pix.pixel;
    end else begin
      row_max_nxt = row_max_r;
    end

    if (xend) begin
      xph_nxt  = '0;
      ocol_nxt = (ocol_r != OCOL_MAX) ? ocol_r + 1'b1 : ocol_r;
    end else begin
      xph_nxt  = xph_r + 1'b1;
      ocol_nxt = ocol_r;
    end

    row_nxt = row_r;
    yph_nxt = yph_r;
    col_nxt = col_r + 1'b1;
    if (col_end) begin
      col_nxt  = '0;
      xph_nxt  = '0;
      ocol_nxt = '0;
      if (row_end) begin
        row_nxt = '0;
        yph_nxt = '0;
      end else begin
        row_nxt = row_r + 1'b1;
        yph_nxt = yend ? '0 : yph_r + 1'b1;
      end
    end
  end

  assign req.vld     = fire & xend & in_limit;
  assign req.idx     = ocol_r;
  assign req.restart = (yph_r == '0);
  assign req.last    = yend;
  assign req_val     = row_max_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_height_r <= IN_HEIGHT_RST;
      in_width_r  <= IN_WIDTH_RST;
      out_width_r <= OUT_WIDTH_RST;
      stride_x_r  <= STRIDE_RST;
      stride_y_r  <= STRIDE_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_IN_HEIGHT: in_height_r <= cfg_wr.data[CNT_W-1:0];
        REG_IN_WIDTH:  in_width_r  <= cfg_wr.data[CNT_W-1:0];
        REG_OUT_WIDTH: out_width_r <= cfg_wr.data[OW_W-1:0];
        REG_STRIDE_X:  stride_x_r  <= cfg_wr.data[STRIDE_W-1:0];
        REG_STRIDE_Y:  stride_y_r  <= cfg_wr.data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      xph_r     <= '0;
      yph_r     <= '0;
      ocol_r    <= '0;
      row_max_r <= '0;
    end else if (fire) begin
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      xph_r     <= xph_nxt;
      yph_r     <= yph_nxt;
      ocol_r    <= ocol_nxt;
      row_max_r <= row_max_nxt;
    end
  end

endmodule

/* hw/rtl/mp2d_line.sv */
// line buffer of column maxima: read, compare, write back, result register
// depends on mp2d_pkg, mp2d_pool_if
module mp2d_line
  import mp2d_pkg::*;
#(
  parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF,
  parameter int LINE_DEPTH  = LINE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  line_req_t                     req,
  input  logic signed [PIXEL_WIDTH-1:0] req_val,
  output logic                          adv,
  mp2d_pool_if.source                   out_pool
);

  localparam int AW = $clog2(LINE_DEPTH);

  logic signed [PIXEL_WIDTH-1:0] mem [LINE_DEPTH];
  logic signed [PIXEL_WIDTH-1:0] rd_data_r;

  logic                          s1_vld_r, s1_restart_r, s1_last_r;
  logic [OCOL_W-1:0]             s1_idx_r;
  logic signed [PIXEL_WIDTH-1:0] s1_val_r;

  // last value written back, covers a read issued in the same cycle as the write
  logic                          fwd_vld_r;
  logic [OCOL_W-1:0]             fwd_idx_r;
  logic signed [PIXEL_WIDTH-1:0] fwd_val_r;

  logic                          out_vld_r;
  logic signed [PIXEL_WIDTH-1:0] out_pooled_r;

  logic signed [PIXEL_WIDTH-1:0] old_val, new_val;

  assign adv = !out_vld_r || out_pool.ready;

  assign old_val = (fwd_vld_r && fwd_idx_r == s1_idx_r) ? fwd_val_r : rd_data_r;
  assign new_val = (s1_restart_r || s1_val_r > old_val) ? s1_val_r : old_val;

  always_ff @(posedge clk) begin
    if (adv && req.vld) begin
      rd_data_r <= mem[AW'(req.idx)];
    end
    if (adv && s1_vld_r) begin
      mem[AW'(s1_idx_r)] <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx_r     <= req.idx;
      s1_restart_r <= req.restart;
      s1_last_r    <= req.last;
      s1_val_r     <= req_val;
      out_pooled_r <= new_val;
      if (s1_vld_r) begin
        fwd_idx_r <= s1_idx_r;
        fwd_val_r <= new_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= req.vld;
      out_vld_r <= s1_vld_r & s1_last_r;
      if (s1_vld_r) begin
        fwd_vld_r <= 1'b1;
      end
    end
  end

  assign out_pool.valid  = out_vld_r;
  assign out_pool.pooled = out_pooled_r;

endmodule

/* hw/rtl/max_pool_2d_stream_top.sv */
// Non-overlapping 2-d max pooling over a raster stream of signed pixels. The
// block takes one pixel word per clock unless stalled; a pooled word passes
// the s1 and result registers after the pixel that closes its window. The
// rate is set by the line buffer, one synchronous memory with one read and
// one write per cycle; a write back the next read would miss is forwarded
// from a register. A stalled result word holds the whole pipeline, including
// the input. The line buffer needs no clearing after reset: the first row
// of each vertical window writes its entries before any later row reads them.
// The user must write registers only while idle; the block does not check it.
// depends on mp2d_pkg, the channel interfaces, mp2d_ctrl and mp2d_line
module max_pool_2d_stream_top
  import mp2d_pkg::*;
#(
  parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF,
  parameter int LINE_DEPTH  = LINE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mp2d_pix_if.sink     in_pix,
  mp2d_pool_if.source  out_pool,
  mp2d_cfg_if.sink     cfg_wr
);

  line_req_t                     req;
  logic signed [PIXEL_WIDTH-1:0] req_val;
  logic                          adv;

  mp2d_ctrl #(
    .PIXEL_WIDTH (PIXEL_WIDTH),
    .LINE_DEPTH  (LINE_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .cfg_wr  (cfg_wr),
    .adv     (adv),
    .req     (req),
    .req_val (req_val)
  );

  mp2d_line #(
    .PIXEL_WIDTH (PIXEL_WIDTH),
    .LINE_DEPTH  (LINE_DEPTH)
  ) u_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .req_val  (req_val),
    .adv      (adv),
    .out_pool (out_pool)
  );

endmodule

/* test/tb_max_pool_2d_stream_top.sv */
// testbench for max_pool_2d_stream_top: pixel frames under many window settings, every
// pooled word checked against an in-line prediction of the pooling
// depends on mp2d_pkg, the three channel interfaces and max_pool_2d_stream_top
module tb_max_pool_2d_stream_top;
  import mp2d_pkg::*;

  localparam int PW            = PIXEL_WIDTH_DEF;
  localparam int LD            = LINE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT   = 5000;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef logic signed [PW-1:0] pixel_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  mp2d_pix_if  #(.W(PW)) pix_ch ();
  mp2d_pool_if #(.W(PW)) pool_ch ();
  mp2d_cfg_if            cfg_ch ();

  max_pool_2d_stream_top #(
    .PIXEL_WIDTH(PW),
    .LINE_DEPTH (LD)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch.sink),
    .out_pool(pool_ch.source),
    .cfg_wr  (cfg_ch.sink)
  );

  // pooling state as the block should hold it
  logic [CNT_W-1:0]    frame_rows, frame_cols;
  logic [OW_W-1:0]     pooled_cols;
  logic [STRIDE_W-1:0] win_w, win_h;
  logic [CNT_W-1:0]    row_pos, col_pos;
  logic [PH_W-1:0]     x_phase, y_phase;
  logic [OCOL_W-1:0]   line_col;
  pixel_t              run_peak;
  pixel_t              col_peak [LD];

  pixel_t pending_pooled [$];
  int     mismatches   = 0;
  int     pixels_sent  = 0;
  int     tx_gap_pct   = 0;
  int     rx_stall_pct = 0;
  int     idle_cycles  = 0;

  function automatic int clamp_window(input logic [STRIDE_W-1:0] s);
    if (s == '0) return 1;
    if (s > 5'd16) return 16;
    return int'(s);
  endfunction

  function void pool_pixel(input pixel_t px);
    int     sx, sy, lim;
    pixel_t peak;
    sx  = clamp_window(win_w);
    sy  = clamp_window(win_h);
    lim = (int'(pooled_cols) < LD) ? int'(pooled_cols) : LD;
    if (x_phase == '0 || px > run_peak) run_peak = px;
    if (int'(x_phase) + 1 >= sx) begin
      if (int'(line_col) < lim) begin
        peak = run_peak;
        if (y_phase == '0 || peak > col_peak[line_col]) begin
          col_peak[line_col] = peak;
        end else begin
          peak = col_peak[line_col];
        end
        if (int'(y_phase) + 1 >= sy) pending_pooled.push_back(peak);
      end
      // column index saturates, later maxima land on the last entry
      if (line_col != OCOL_MAX) line_col++;
      x_phase = '0;
    end else begin
      x_phase++;
    end
    if (int'(col_pos) + 1 >= int'(frame_cols)) begin
      col_pos  = '0;
      x_phase  = '0;
      line_col = '0;
      if (int'(row_pos) + 1 >= int'(frame_rows)) begin
        row_pos = '0;
        y_phase = '0;
      end else begin
        row_pos++;
        if (int'(y_phase) + 1 >= sy) y_phase = '0;
        else y_phase++;
      end
    end else begin
      col_pos++;
    end
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t r;
    case ($urandom_range(0, 7))
      0: r = {1'b1, {(PW-1){1'b0}}};
      1: r = {1'b0, {(PW-1){1'b1}}};
      2, 3: r = pixel_t'($urandom_range(0, 4)) - pixel_t'(2);  // near zero, plenty of ties
      default: r = pixel_t'($urandom);
    endcase
    return r;
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        tx_gap_pct = 0; rx_stall_pct = 0;
      end
      IDLE_SENDER: begin
        tx_gap_pct = 79; rx_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        tx_gap_pct = 0; rx_stall_pct = 79;
      end
      default: begin
        tx_gap_pct = 20; rx_stall_pct = 20;
      end
    endcase
  endtask

  // valid stays high into the next word unless a gap is drawn
  task automatic send_pixel(input pixel_t px);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_gap_pct) gap++;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    do @(posedge clk); while (!(pix_ch.valid && pix_ch.ready));
    pool_pixel(px);
    pixels_sent++;
  endtask

  task automatic send_n(input int n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  // at least one word, then on to the start of the next frame
  task automatic send_frame_rest();
    do send_pixel(rand_pixel()); while (row_pos != '0 || col_pos != '0);
  endtask

  task automatic flush_pipeline();
    pix_ch.valid <= 1'b0;
    while (pending_pooled.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    case (idx)
      REG_IN_HEIGHT: frame_rows  = val[CNT_W-1:0];
      REG_IN_WIDTH:  frame_cols  = val[CNT_W-1:0];
      REG_OUT_WIDTH: pooled_cols = val[OW_W-1:0];
      REG_STRIDE_X:  win_w       = val[STRIDE_W-1:0];
      REG_STRIDE_Y:  win_h       = val[STRIDE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    flush_pipeline();
    write_reg(idx, val);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_window(input logic [CFG_DATA_W-1:0] h, input logic [CFG_DATA_W-1:0] w,
                            input logic [CFG_DATA_W-1:0] ow, input logic [CFG_DATA_W-1:0] sx,
                            input logic [CFG_DATA_W-1:0] sy);
    flush_pipeline();
    write_reg(REG_IN_HEIGHT, h);
    write_reg(REG_IN_WIDTH, w);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_STRIDE_X, sx);
    write_reg(REG_STRIDE_Y, sy);
    cfg_ch.valid <= 1'b0;
  endtask

  // reset sizes, then the height cut below the row counter ends the frame early
  task automatic test_reset_config();
    set_idle(IDLE_SENDER);
    send_n(40);
    write_one(REG_IN_HEIGHT, 12'd1);
    send_frame_rest();
  endtask

  task automatic test_pixel_extremes();
    pixel_t corner_px [12];
    pixel_t single_px [4];
    corner_px = '{16'sh8000, 16'sh8000, 16'sh7FFF, -16'sd1, 16'sd0, -16'sd1,
                  16'sh8000, 16'sh8001, 16'sd0, 16'sh7FFF, -16'sd1, -16'sd2};
    single_px = '{16'sh8000, 16'sh7FFF, -16'sd1, 16'sd0};
    set_idle(IDLE_NONE);
    set_window(12'd2, 12'd6, 12'd3, 12'd2, 12'd2);
    write_one(REG_SPARE, 12'hABC);
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    set_window(12'd1, 12'd4, 12'd4, 12'd1, 12'd1);
    foreach (single_px[i]) send_pixel(single_px[i]);
  endtask

  task automatic test_edge_leftovers();
    set_idle(IDLE_RECEIVER);
    set_window(12'd4, 12'd9, 12'd4, 12'd2, 12'd2);
    send_frame_rest();
    set_window(12'd5, 12'd8, 12'd4, 12'd2, 12'd2);
    send_frame_rest();
    // out_width below the column maxima in a row
    set_window(12'd3, 12'd12, 12'd2, 12'd2, 12'd1);
    send_frame_rest();
  endtask

  task automatic test_stride_limits();
    set_idle(IDLE_BOTH);
    set_window(12'd3, 12'd16, 12'd1, 12'd16, 12'd3);
    send_frame_rest();
    // upper data bits fall outside the stride fields: zero and sixteen
    set_window(12'd16, 12'd3, 12'd3, 12'hFE0, 12'hFF0);
    send_frame_rest();
    set_window(12'd2, 12'd16, 12'd1, 12'h01F, 12'd1);
    send_frame_rest();
    set_window(12'd16, 12'd1, 12'd1, 12'd1, 12'h011);
    send_frame_rest();
  endtask

  task automatic test_zero_sizes();
    set_idle(IDLE_SENDER);
    set_window(12'd0, 12'd0, 12'd1, 12'd1, 12'd1);
    send_n(12);
    set_window(12'd3, 12'd0, 12'd1, 12'd1, 12'd2);
    send_frame_rest();
    set_window(12'd2, 12'd4, 12'd0, 12'd1, 12'd1);
    send_frame_rest();
  endtask

  task automatic test_height_lowered();
    set_idle(IDLE_NONE);
    set_window(12'hFFF, 12'd2, 12'd1024, 12'd2, 12'd2);
    send_n(12);
    write_one(REG_IN_HEIGHT, 12'd1);
    send_frame_rest();
  endtask

  // single-row windows only, so no entry is read before this row writes it
  task automatic test_width_lowered();
    set_idle(IDLE_BOTH);
    set_window(12'd3, 12'hFFF, 12'hFFF, 12'd1, 12'd1);
    send_n(100);
    write_one(REG_IN_WIDTH, 12'd1);
    send_frame_rest();
  endtask

  task automatic test_random_settings();
    int start, round, h, w, sx, sy, ow;
    start = pixels_sent;
    round = 0;
    while (pixels_sent - start < 70) begin
      set_idle(idle_mode_t'(round % 4));
      h  = $urandom_range(1, 6);
      w  = $urandom_range(1, 12);
      sx = $urandom_range(0, 5);
      sy = $urandom_range(1, 3);
      ow = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : w / ((sx == 0) ? 1 : sx);
      set_window(CFG_DATA_W'(h), CFG_DATA_W'(w), CFG_DATA_W'(ow), CFG_DATA_W'(sx),
                 CFG_DATA_W'(sy));
      repeat ($urandom_range(1, 2)) send_frame_rest();
      round++;
    end
  endtask

  always @(posedge clk) pool_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);

  always @(posedge clk) begin : check_pooled
    pixel_t want;
    if (rst_n) begin
      if (pool_ch.valid && pool_ch.ready) begin
        if (pending_pooled.size() == 0) begin
          $error("pooled: expected no word, actual %0d", pool_ch.pooled);
          mismatches++;
        end else begin
          want = pending_pooled.pop_front();
          if (pool_ch.pooled !== want) begin
            $error("pooled: expected %0d, actual %0d", want, pool_ch.pooled);
            mismatches++;
          end
        end
      end
      if ((pix_ch.valid && pix_ch.ready) || (pool_ch.valid && pool_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    pix_ch.valid  = 1'b0;
    pix_ch.pixel  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    frame_rows    = IN_HEIGHT_RST;
    frame_cols    = IN_WIDTH_RST;
    pooled_cols   = OUT_WIDTH_RST;
    win_w         = STRIDE_RST;
    win_h         = STRIDE_RST;
    row_pos       = '0;
    col_pos       = '0;
    x_phase       = '0;
    y_phase       = '0;
    line_col      = '0;
    run_peak      = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_pixel_extremes();
    test_edge_leftovers();
    test_stride_limits();
    test_zero_sizes();
    test_height_lowered();
    test_width_lowered();
    test_random_settings();
    flush_pipeline();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
